### rtl/mvoa_pkg.sv
// Shared types and codes for the mono voice allocator.
// No dependencies; the front, queue, back and top files refer to it by scoped names.
`timescale 1ns / 1ps

package mvoa_pkg;

    // Event kinds on the input mode field
    localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
    localparam logic [1:0] MODE_BEND     = 2'd2;
    localparam logic [1:0] MODE_CTRL     = 2'd3;

    localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;

    // Bend ratio of one in Q2.16
    localparam logic [17:0] BEND_UNITY = 18'd65536;

    typedef enum logic [2:0] {
        CMD_NOTE_ON,
        CMD_NOTE_OFF,
        CMD_BEND,
        CMD_ALL_OFF,
        CMD_NOP
    } cmd_t;

    // One classified event between front and back
    typedef struct packed {
        cmd_t        cmd;
        logic [6:0]  note;
        logic [11:0] exp_arg;
        logic [1:0]  bend_shift;
    } cmd_entry_t;

endpackage

### rtl/mvoa_exp2.sv
// Iterative 2^(f/4096) unit, Q1.24 result, one multiply per cycle while busy, one step per argument bit.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module mvoa_exp2 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [11:0] arg,
    output logic        done,
    output logic [24:0] result
);

    localparam int         STEPS = 12;
    localparam logic [24:0] ONE  = 25'h1000000;
    localparam logic [49:0] HALF = 50'h800000;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  step_reg, step_next;
    logic [11:0] arg_reg;
    logic [24:0] acc_reg, acc_next;
    logic [24:0] step_factor;
    logic [49:0] prod;
    logic [49:0] rounded;

    function automatic logic [24:0] exp_step(input logic [3:0] idx);
        logic [24:0] val;
        case (idx)
            4'd0:    val = 25'd16780055;
            4'd1:    val = 25'd16782895;
            4'd2:    val = 25'd16788576;
            4'd3:    val = 25'd16799944;
            4'd4:    val = 25'd16822704;
            4'd5:    val = 25'd16868315;
            4'd6:    val = 25'd16959908;
            4'd7:    val = 25'd17144589;
            4'd8:    val = 25'd17520007;
            4'd9:    val = 25'd18295684;
            4'd10:   val = 25'd19951585;
            4'd11:   val = 25'd23726566;
            default: val = ONE;
        endcase
        return val;
    endfunction

    assign step_factor = exp_step(step_reg);
    assign prod        = {25'd0, acc_reg} * {25'd0, step_factor};
    assign rounded     = prod + HALF;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = 4'd0;
            acc_next  = ONE;
        end else if (busy_reg) begin
            if (arg_reg[step_reg]) begin
                acc_next = rounded[48:24];
            end
            step_next = step_reg + 4'd1;
            if (step_reg == 4'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (start) begin
            arg_reg <= arg;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

### rtl/mvoa_front.sv
// Front end: registers each MIDI event, classifies it and prepares the exp2 argument.
// Depends on mvoa_pkg for the event codes and the queue entry type.
`timescale 1ns / 1ps

module mvoa_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_mode,
    input  logic [6:0]           s_note,
    input  logic [6:0]           s_velocity,
    input  logic signed [13:0]   s_bend_value,
    input  logic [6:0]           s_controller,
    output logic                 q_wr_valid,
    input  logic                 q_wr_ready,
    output mvoa_pkg::cmd_entry_t q_wr_data
);

    logic               hold_valid_reg, hold_valid_next;
    logic [1:0]         mode_reg;
    logic [6:0]         note_reg;
    logic [6:0]         vel_reg;
    logic signed [13:0] bend_reg;
    logic [6:0]         ctl_reg;
    logic               s_accept;

    logic [23:0] num;
    logic [24:0] approx;
    logic [12:0] q0;
    logic [25:0] rem;
    logic [12:0] quot;
    logic [13:0] bend_u;

    assign s_ready  = !hold_valid_reg || q_wr_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (s_accept) begin
            hold_valid_next = 1'b1;
        end else if (q_wr_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg <= s_mode;
            note_reg <= s_note;
            vel_reg  <= s_velocity;
            bend_reg <= s_bend_value;
            ctl_reg  <= s_controller;
        end
    end

    // Velocity to exp2 argument: (vel * 2^17 + 2047) / 4095 by reciprocal plus one correction
    always_comb begin
        num    = {vel_reg, 17'd0} + 24'd2047;
        approx = {1'b0, num} + {13'd0, num[23:12]};
        q0     = approx[24:12];
        rem    = {2'b00, num} - {1'b0, q0, 12'd0} + {13'd0, q0};
        quot   = (rem >= 26'd4095) ? q0 + 13'd1 : q0;
    end

    // Offset binary wheel position: flip the sign bit
    assign bend_u = {~bend_reg[13], bend_reg[12:0]};

    always_comb begin
        q_wr_data.note       = note_reg;
        q_wr_data.exp_arg    = 12'd0;
        q_wr_data.bend_shift = 2'd0;
        case (mode_reg)
            mvoa_pkg::MODE_NOTE_ON: begin
                q_wr_data.cmd     = mvoa_pkg::CMD_NOTE_ON;
                q_wr_data.exp_arg = quot[11:0];
            end
            mvoa_pkg::MODE_NOTE_OFF: begin
                q_wr_data.cmd = mvoa_pkg::CMD_NOTE_OFF;
            end
            mvoa_pkg::MODE_BEND: begin
                q_wr_data.cmd        = mvoa_pkg::CMD_BEND;
                q_wr_data.exp_arg    = bend_u[11:0];
                q_wr_data.bend_shift = bend_u[13:12];
            end
            mvoa_pkg::MODE_CTRL: begin
                q_wr_data.cmd = (ctl_reg == mvoa_pkg::CC_ALL_NOTES_OFF) ?
                                mvoa_pkg::CMD_ALL_OFF : mvoa_pkg::CMD_NOP;
            end
            default: begin
                q_wr_data.cmd = mvoa_pkg::CMD_NOP;
            end
        endcase
    end

    assign q_wr_valid = hold_valid_reg;

endmodule

### rtl/mvoa_queue.sv
// Two-entry queue of classified events between front and back.
// Depends on mvoa_pkg for the entry type.
`timescale 1ns / 1ps

module mvoa_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  mvoa_pkg::cmd_entry_t wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output mvoa_pkg::cmd_entry_t rd_data
);

    localparam logic [1:0] Q_DEPTH = 2'd2;

    mvoa_pkg::cmd_entry_t entries [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign wr_ready = (count_reg != Q_DEPTH);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entries[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/mvoa_back.sv
// Back end: held-note stack in a memory, sequencer for search and close-up,
// note frequency stage and output register. Depends on mvoa_pkg and mvoa_exp2.
`timescale 1ns / 1ps

module mvoa_back #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_rd_valid,
    output logic                 q_rd_ready,
    input  mvoa_pkg::cmd_entry_t q_rd_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [6:0]           m_key_note,
    output logic [23:0]          m_freq_hz,
    output logic [15:0]          m_gain_level,
    output logic                 m_gate_open,
    output logic [18:0]          m_bend_ratio,
    output logic [4:0]           m_held_count
);

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SEARCH = 7'b0000010,
        ST_SHIFT  = 7'b0000100,
        ST_KEY    = 7'b0001000,
        ST_EXP    = 7'b0010000,
        ST_FREQ   = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    mvoa_pkg::cmd_t      cmd_reg, cmd_next;
    logic [6:0]          note_reg, note_next;
    logic [1:0]          shift_reg, shift_next;
    logic [CNT_W-1:0]    depth_reg, depth_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [6:0]          key_reg, key_next;
    logic [23:0]         freq_reg, freq_next;
    logic [15:0]         gain_reg, gain_next;
    logic                gate_reg, gate_next;
    logic [17:0]         bend_reg, bend_next;

    logic                m_valid_reg, m_valid_next;
    logic                out_load;
    logic [6:0]          out_key_reg;
    logic [23:0]         out_freq_reg;
    logic [15:0]         out_gain_reg;
    logic                out_gate_reg;
    logic [17:0]         out_bend_reg;
    logic [4:0]          out_count_reg;

    logic [6:0]          held_mem [STACK_DEPTH];
    logic [6:0]          rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic [6:0]          wr_data;
    logic                wr_en;

    logic [CNT_W:0]      idx_p1, idx_p2;
    logic [CNT_W-1:0]    depth_m1;

    logic                exp_start;
    logic                exp_done;
    logic [24:0]         exp_result;
    logic [24:0]         gain_sum;
    logic [27:0]         bend_sum;

    function automatic logic [29:0] freq_base(input logic [3:0] k);
        logic [29:0] val;
        case (k)
            4'd0:    val = 30'd461373440;
            4'd1:    val = 30'd488808320;
            4'd2:    val = 30'd517876480;
            4'd3:    val = 30'd548669440;
            4'd4:    val = 30'd581292800;
            4'd5:    val = 30'd615859200;
            4'd6:    val = 30'd652481280;
            4'd7:    val = 30'd691278720;
            4'd8:    val = 30'd732385280;
            4'd9:    val = 30'd775934720;
            4'd10:   val = 30'd822074880;
            4'd11:   val = 30'd870953600;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

    // Octave by multiply with 171/2048, semitone table, shift and round
    function automatic logic [23:0] note_freq(input logic [6:0] note);
        logic [7:0]  m;
        logic [15:0] prod;
        logic [3:0]  oct;
        logic [7:0]  k8;
        logic [39:0] v;
        logic [40:0] sum;
        m    = {1'b0, note} + 8'd3;
        prod = {8'd0, m} * 16'd171;
        oct  = prod[14:11];
        k8   = m - ({1'b0, oct, 3'b000} + {2'b00, oct, 2'b00});
        v    = {10'd0, freq_base(k8[3:0])} << oct;
        sum  = {1'b0, v} + 41'd32768;
        return sum[39:16];
    endfunction

    mvoa_exp2 u_exp2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (exp_start),
        .arg     (q_rd_data.exp_arg),
        .done    (exp_done),
        .result  (exp_result)
    );

    assign idx_p1   = {1'b0, idx_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign idx_p2   = {1'b0, idx_reg} + {{(CNT_W - 1){1'b0}}, 2'd2};
    assign depth_m1 = depth_reg - {{(CNT_W - 1){1'b0}}, 1'b1};

    assign gain_sum = exp_result - 25'h1000000 + 25'd128;
    assign bend_sum = ({3'b000, exp_result} << shift_reg) + 28'd512;

    assign q_rd_ready = (state_reg == ST_IDLE);
    assign exp_start  = (state_reg == ST_IDLE) && q_rd_valid &&
                        ((q_rd_data.cmd == mvoa_pkg::CMD_NOTE_ON) ||
                         (q_rd_data.cmd == mvoa_pkg::CMD_BEND));

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        note_next  = note_reg;
        shift_next = shift_reg;
        depth_next = depth_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        freq_next  = freq_reg;
        gain_next  = gain_reg;
        gate_next  = gate_reg;
        bend_next  = bend_reg;
        rd_addr    = idx_p1[IDX_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = idx_reg[IDX_W-1:0];
        wr_data    = rd_data_reg;
        out_load   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                rd_addr = '0;
                idx_next = '0;
                if (q_rd_valid) begin
                    cmd_next   = q_rd_data.cmd;
                    note_next  = q_rd_data.note;
                    shift_next = q_rd_data.bend_shift;
                    case (q_rd_data.cmd)
                        mvoa_pkg::CMD_NOTE_ON: begin
                            if (depth_reg < CNT_W'(STACK_DEPTH)) begin
                                wr_en      = 1'b1;
                                wr_addr    = depth_reg[IDX_W-1:0];
                                wr_data    = q_rd_data.note;
                                depth_next = depth_reg + {{(CNT_W - 1){1'b0}}, 1'b1};
                            end
                            key_next   = q_rd_data.note;
                            gate_next  = 1'b1;
                            state_next = ST_EXP;
                        end
                        mvoa_pkg::CMD_NOTE_OFF: begin
                            state_next = ST_SEARCH;
                        end
                        mvoa_pkg::CMD_BEND: begin
                            state_next = ST_EXP;
                        end
                        mvoa_pkg::CMD_ALL_OFF: begin
                            depth_next = '0;
                            gate_next  = 1'b0;
                            bend_next  = mvoa_pkg::BEND_UNITY;
                            state_next = ST_OUT;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // rd_data_reg holds entry idx_reg here
                if (idx_reg >= depth_reg) begin
                    state_next = ST_OUT;
                end else if (rd_data_reg == note_reg) begin
                    if (depth_reg > {{(CNT_W - 1){1'b0}}, 1'b1}) begin
                        depth_next = depth_m1;
                        state_next = ST_SHIFT;
                    end else begin
                        depth_next = '0;
                        gate_next  = 1'b0;
                        state_next = ST_OUT;
                    end
                end else begin
                    idx_next = idx_p1[CNT_W-1:0];
                end
            end
            ST_SHIFT: begin
                // rd_data_reg holds entry idx_reg + 1; move it down one place
                if (idx_reg < depth_reg) begin
                    wr_en    = 1'b1;
                    rd_addr  = idx_p2[IDX_W-1:0];
                    idx_next = idx_p1[CNT_W-1:0];
                end else begin
                    rd_addr    = depth_m1[IDX_W-1:0];
                    state_next = ST_KEY;
                end
            end
            ST_KEY: begin
                key_next   = rd_data_reg;
                state_next = ST_FREQ;
            end
            ST_EXP: begin
                if (exp_done) begin
                    if (cmd_reg == mvoa_pkg::CMD_NOTE_ON) begin
                        gain_next  = gain_sum[23:8];
                        state_next = ST_FREQ;
                    end else begin
                        bend_next  = bend_sum[27:10];
                        state_next = ST_OUT;
                    end
                end
            end
            ST_FREQ: begin
                freq_next  = note_freq(key_reg);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmd_reg     <= mvoa_pkg::CMD_NOP;
            depth_reg   <= '0;
            idx_reg     <= '0;
            key_reg     <= 7'd0;
            freq_reg    <= 24'd0;
            gain_reg    <= 16'd0;
            gate_reg    <= 1'b0;
            bend_reg    <= mvoa_pkg::BEND_UNITY;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            depth_reg   <= depth_next;
            idx_reg     <= idx_next;
            key_reg     <= key_next;
            freq_reg    <= freq_next;
            gain_reg    <= gain_next;
            gate_reg    <= gate_next;
            bend_reg    <= bend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        note_reg  <= note_next;
        shift_reg <= shift_next;
        if (out_load) begin
            out_key_reg   <= key_reg;
            out_freq_reg  <= freq_reg;
            out_gain_reg  <= gain_reg;
            out_gate_reg  <= gate_reg;
            out_bend_reg  <= bend_reg;
            out_count_reg <= 5'(depth_reg);
        end
    end

    // Held-note stack: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            held_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= held_mem[rd_addr];
    end

    assign m_valid      = m_valid_reg;
    assign m_key_note   = out_key_reg;
    assign m_freq_hz    = out_freq_reg;
    assign m_gain_level = out_gain_reg;
    assign m_gate_open  = out_gate_reg;
    assign m_bend_ratio = {1'b0, out_bend_reg};
    assign m_held_count = out_count_reg;

endmodule

### rtl/mono_voice_allocator_top.sv
// Monophonic last-note-priority voice allocator, top level.
// Depends on mvoa_pkg, mvoa_front, mvoa_queue and mvoa_back.
//
// Usage:
//   Input channel s_*: one MIDI event per transfer (mode, note, velocity,
//   bend_value, controller). Output channel m_*: exactly one result per
//   event, holding key, frequency (Q14.10), gain (Q0.16), gate, bend ratio
//   (Q2.16) and the number of held notes after that event.
//   Events pass an input register and a two-entry queue, then a sequencer.
//   Steps from input transfer to m_valid, after input register and queue:
//     control change: straight to the output register
//     pitch bend:     12 exp2 steps, one multiply each, then output
//     note on:        exp2 steps, then the frequency stage, then output
//     note off:       stack search entry by entry; on a hit in a deeper stack,
//                     close-up of the entries above it, read of the new top key
//                     and frequency stage; an unheld or the last note goes out.
//   The sequencer takes a new event only from idle; the stack memory port,
//   one entry a cycle, paces the note-off search and close-up.
//   Reset empties the stack, zeroes key, frequency, gain and gate and sets the
//   bend ratio to one. A stalled receiver holds the result in the output
//   register while the next event is processed; the queue then fills and
//   s_ready drops.
`timescale 1ns / 1ps

module mono_voice_allocator_top #(
    parameter int STACK_DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [6:0]         s_note,
    input  logic [6:0]         s_velocity,
    input  logic signed [13:0] s_bend_value,
    input  logic [6:0]         s_controller,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [6:0]         m_key_note,
    output logic [23:0]        m_freq_hz,
    output logic [15:0]        m_gain_level,
    output logic               m_gate_open,
    output logic [18:0]        m_bend_ratio,
    output logic [4:0]         m_held_count
);

    logic                 q_wr_valid, q_wr_ready;
    mvoa_pkg::cmd_entry_t q_wr_data;
    logic                 q_rd_valid, q_rd_ready;
    mvoa_pkg::cmd_entry_t q_rd_data;

    mvoa_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_note       (s_note),
        .s_velocity   (s_velocity),
        .s_bend_value (s_bend_value),
        .s_controller (s_controller),
        .q_wr_valid   (q_wr_valid),
        .q_wr_ready   (q_wr_ready),
        .q_wr_data    (q_wr_data)
    );

    mvoa_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    mvoa_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_rd_valid   (q_rd_valid),
        .q_rd_ready   (q_rd_ready),
        .q_rd_data    (q_rd_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_note   (m_key_note),
        .m_freq_hz    (m_freq_hz),
        .m_gain_level (m_gain_level),
        .m_gate_open  (m_gate_open),
        .m_bend_ratio (m_bend_ratio),
        .m_held_count (m_held_count)
    );

endmodule

### rtl/mvoa_checker.sv
// Port-level checks for mono_voice_allocator_top, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module mvoa_checker #(
    parameter int STACK_DEPTH = 16
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_mode,
    input logic [6:0]         s_note,
    input logic [6:0]         s_velocity,
    input logic signed [13:0] s_bend_value,
    input logic [6:0]         s_controller,
    input logic               m_valid,
    input logic               m_ready,
    input logic [6:0]         m_key_note,
    input logic [23:0]        m_freq_hz,
    input logic [15:0]        m_gain_level,
    input logic               m_gate_open,
    input logic [18:0]        m_bend_ratio,
    input logic [4:0]         m_held_count
);

    // Hold a stalled event on the input side
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_mode) && $stable(s_note) &&
            $stable(s_velocity) && $stable(s_bend_value) && $stable(s_controller)))
        else $error("input event changed or dropped while stalled");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_key_note) && $stable(m_freq_hz) &&
            $stable(m_gain_level) && $stable(m_gate_open) && $stable(m_bend_ratio) &&
            $stable(m_held_count)))
        else $error("result changed or dropped while stalled");

    // Gate is open exactly while notes are held
    a_gate_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (STACK_DEPTH < 32)) |-> (m_gate_open == (m_held_count != 5'd0)))
        else $error("gate does not match held note count");

    // Bend ratio never drops below one quarter
    a_bend_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bend_ratio >= 19'd16384))
        else $error("bend ratio below lower limit");

endmodule

bind mono_voice_allocator_top mvoa_checker #(.STACK_DEPTH(STACK_DEPTH)) u_mvoa_checker (.*);
